// File: rtl/lcfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcfs_pkg
// types and constants shared by the led chain frame serializer
// ----------------------------------------------------------------------------
package lcfs_pkg;

    localparam int unsigned COLOR_W     = 24;
    localparam int unsigned COUNT_W     = 11;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned PEND_W      = 7;
    localparam int unsigned ACC_W       = PEND_W + COLOR_W + 1;
    localparam int unsigned SHIFT_W     = 5;

    // bits per led: delimiter plus 24 color bits
    localparam logic [5:0] LED_BITS     = 6'd25;
    localparam logic       DELIM_BIT    = 1'b1;
    // header pad count 6 or more gives seven leading zero bytes, else six
    localparam logic [2:0] PAD_LONG_MIN = 3'd6;
    localparam logic [2:0] HDR_BYTES_S  = 3'd6;
    localparam logic [2:0] HDR_BYTES_L  = 3'd7;
    // 50 header bits leave 2 bits beyond whole bytes
    localparam logic [2:0] HDR_REM      = 3'd2;

    typedef struct packed {
        logic [ACC_W-1:0]   acc;
        logic [SHIFT_W-1:0] shift;
        logic [2:0]         zero_bytes;
        logic [2:0]         data_bytes;
        logic               frame_end;
    } t_job;

    typedef struct packed {
        logic busy;
        logic zero_phase;
    } t_emit_status;

endpackage

// File: rtl/lcfs_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcfs_in_if
// color request channel
// ----------------------------------------------------------------------------
interface lcfs_in_if;
    logic                          valid;
    logic                          ready;
    logic [lcfs_pkg::COLOR_W-1:0]  color;

    modport source (output valid, output color, input ready);
    modport sink   (input valid, input color, output ready);
endinterface

// File: rtl/lcfs_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcfs_out_if
// byte stream request channel
// ----------------------------------------------------------------------------
interface lcfs_out_if;
    logic                         valid;
    logic                         ready;
    logic [lcfs_pkg::BYTE_W-1:0]  data_byte;
    logic                         last_in_item;
    logic                         last_of_frame;

    modport source (output valid, output data_byte, output last_in_item,
                    output last_of_frame, input ready);
    modport sink   (input valid, input data_byte, input last_in_item,
                    input last_of_frame, output ready);
endinterface

// File: rtl/lcfs_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcfs_cfg_if
// led count register write channel
// ----------------------------------------------------------------------------
interface lcfs_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [lcfs_pkg::COUNT_W-1:0]  led_count;

    modport source (output valid, output led_count, input ready);
    modport sink   (input valid, input led_count, output ready);
endinterface

// File: rtl/lcfs_packer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcfs_packer
// frame state and per-led bit packing into a byte job
// ----------------------------------------------------------------------------
module lcfs_packer #(
    parameter int unsigned MAX_LEDS = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [lcfs_pkg::COUNT_W-1:0]  i_cfg_count,
    input  logic                          i_accept,
    input  logic [lcfs_pkg::COLOR_W-1:0]  i_color,
    output lcfs_pkg::t_job                o_job
);

    logic [lcfs_pkg::COUNT_W-1:0] r_led_count, n_led_count;
    logic [lcfs_pkg::PEND_W-1:0]  r_pend_bits, n_pend_bits;
    logic [2:0]                   r_pend_cnt, n_pend_cnt;
    logic [lcfs_pkg::COUNT_W-1:0] r_led_index, n_led_index;

    logic [lcfs_pkg::COUNT_W-1:0] eff_count;
    logic [lcfs_pkg::COUNT_W-1:0] idx;
    logic                         first;
    logic                         frame_end;
    logic [2:0]                   pad;
    logic [2:0]                   pc0;
    logic [lcfs_pkg::PEND_W-1:0]  pb0;
    logic [24:0]                  word;
    logic [lcfs_pkg::ACC_W-1:0]   acc;
    logic [5:0]                   cnt;
    logic [lcfs_pkg::PEND_W-1:0]  mask;

    always_comb begin
        if (r_led_count == '0) begin
            eff_count = lcfs_pkg::COUNT_W'(1);
        end else if ({6'd0, r_led_count} > 17'(MAX_LEDS)) begin
            eff_count = lcfs_pkg::COUNT_W'(MAX_LEDS);
        end else begin
            eff_count = r_led_count;
        end

        idx       = (r_led_index >= eff_count) ? '0 : r_led_index;
        first     = (idx == '0);
        frame_end = (({1'b0, idx} + 12'd1) >= {1'b0, eff_count});

        // 25n + 50 is n + 2 mod 8, pad the header up to a byte boundary
        pad = 3'd6 - eff_count[2:0];
        pc0 = first ? (pad + lcfs_pkg::HDR_REM) : r_pend_cnt;
        pb0 = first ? '0 : r_pend_bits;

        // sent as blue, red, green
        word = {lcfs_pkg::DELIM_BIT, i_color[7:0], i_color[23:16], i_color[15:8]};
        acc  = {pb0, word};
        cnt  = {3'd0, pc0} + lcfs_pkg::LED_BITS;
        mask = (lcfs_pkg::PEND_W'(1) << cnt[2:0]) - lcfs_pkg::PEND_W'(1);

        o_job.acc        = acc;
        o_job.shift      = lcfs_pkg::SHIFT_W'(cnt - 6'd8);
        o_job.zero_bytes = first ? ((pad >= lcfs_pkg::PAD_LONG_MIN) ?
                                    lcfs_pkg::HDR_BYTES_L : lcfs_pkg::HDR_BYTES_S)
                                 : 3'd0;
        o_job.data_bytes = cnt[5:3];
        o_job.frame_end  = frame_end;
    end

    always_comb begin
        n_led_count = r_led_count;
        n_pend_bits = r_pend_bits;
        n_pend_cnt  = r_pend_cnt;
        n_led_index = r_led_index;
        if (i_cfg_we) begin
            // a new count aborts the frame in progress
            n_led_count = i_cfg_count;
            n_pend_bits = '0;
            n_pend_cnt  = '0;
            n_led_index = '0;
        end else if (i_accept) begin
            if (frame_end) begin
                n_pend_bits = '0;
                n_pend_cnt  = '0;
                n_led_index = '0;
            end else begin
                n_pend_bits = acc[lcfs_pkg::PEND_W-1:0] & mask;
                n_pend_cnt  = cnt[2:0];
                n_led_index = idx + lcfs_pkg::COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led_count <= lcfs_pkg::COUNT_W'(1);
            r_pend_bits <= '0;
            r_pend_cnt  <= '0;
            r_led_index <= '0;
        end else begin
            r_led_count <= n_led_count;
            r_pend_bits <= n_pend_bits;
            r_pend_cnt  <= n_pend_cnt;
            r_led_index <= n_led_index;
        end
    end

endmodule

// File: rtl/lcfs_emitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcfs_emitter
// job register feeding an output register one byte per cycle while not stalled
// ----------------------------------------------------------------------------
module lcfs_emitter (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_load,
    input  lcfs_pkg::t_job          i_job,
    output logic                    o_in_ready,
    output lcfs_pkg::t_emit_status  o_status,
    lcfs_out_if.source              o_out
);

    logic                           r_busy, n_busy;
    logic [lcfs_pkg::ACC_W-1:0]     r_acc, n_acc;
    logic [lcfs_pkg::SHIFT_W-1:0]   r_shift, n_shift;
    logic [2:0]                     r_zleft, n_zleft;
    logic [2:0]                     r_dleft, n_dleft;
    logic                           r_fe, n_fe;

    logic                           r_ov, n_ov;
    logic [lcfs_pkg::BYTE_W-1:0]    r_byte, n_byte;
    logic                           r_lii, n_lii;
    logic                           r_lof, n_lof;

    logic                           emit;
    logic                           last_data;
    logic                           done;
    logic [lcfs_pkg::BYTE_W-1:0]    shifted;

    always_comb begin
        emit      = r_busy && (!r_ov || o_out.ready);
        last_data = (r_zleft == 3'd0) && (r_dleft == 3'd1);
        done      = emit && last_data;
        shifted   = lcfs_pkg::BYTE_W'(r_acc >> r_shift);

        o_in_ready          = !r_busy || done;
        o_status.busy       = r_busy;
        o_status.zero_phase = r_busy && (r_zleft != 3'd0);

        n_busy  = r_busy;
        n_acc   = r_acc;
        n_shift = r_shift;
        n_zleft = r_zleft;
        n_dleft = r_dleft;
        n_fe    = r_fe;
        if (i_load) begin
            n_busy  = 1'b1;
            n_acc   = i_job.acc;
            n_shift = i_job.shift;
            n_zleft = i_job.zero_bytes;
            n_dleft = i_job.data_bytes;
            n_fe    = i_job.frame_end;
        end else if (done) begin
            n_busy = 1'b0;
        end else if (emit) begin
            if (r_zleft != 3'd0) begin
                n_zleft = r_zleft - 3'd1;
            end else begin
                n_dleft = r_dleft - 3'd1;
                n_shift = r_shift - lcfs_pkg::SHIFT_W'(8);
            end
        end

        n_ov   = emit ? 1'b1 : (o_out.ready ? 1'b0 : r_ov);
        n_byte = r_byte;
        n_lii  = r_lii;
        n_lof  = r_lof;
        if (emit) begin
            n_byte = (r_zleft != 3'd0) ? '0 : shifted;
            n_lii  = last_data;
            n_lof  = last_data && r_fe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_ov   <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc   <= n_acc;
        r_shift <= n_shift;
        r_zleft <= n_zleft;
        r_dleft <= n_dleft;
        r_fe    <= n_fe;
        r_byte  <= n_byte;
        r_lii   <= n_lii;
        r_lof   <= n_lof;
    end

    assign o_out.valid         = r_ov;
    assign o_out.data_byte     = r_byte;
    assign o_out.last_in_item  = r_lii;
    assign o_out.last_of_frame = r_lof;

endmodule

// File: rtl/led_chain_frame_serializer.sv
`timescale 1ns / 1ps
// the first byte of a taken color passes the job register, then the byte output register
// throughput: one byte per cycle unless the output stalls; a color gives 3 or 4 bytes,
// a frame's first 9 to 10 with its leading zero bytes; the output register sets the pace
// a new color is taken in the cycle its predecessor's last byte leaves the job register
// reset: synchronous active low, clears frame position and pending bits, led count to 1
// ----------------------------------------------------------------------------
// led_chain_frame_serializer
// packs per-led colors into the byte stream of an led chain frame
// ----------------------------------------------------------------------------
module led_chain_frame_serializer #(
    parameter int unsigned MAX_LEDS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lcfs_in_if.sink     i_in,
    lcfs_cfg_if.sink    i_cfg,
    lcfs_out_if.source  o_out
);

    lcfs_pkg::t_job          job;
    lcfs_pkg::t_emit_status  emit_status;
    logic                    in_ready;
    logic                    in_accept;
    logic                    cfg_we;

    // register writes are taken at once; the user must issue them only while idle, unchecked
    assign i_cfg.ready = 1'b1;
    assign cfg_we      = i_cfg.valid;

    // a color request is taken whenever the job register frees up this cycle
    assign i_in.ready = in_ready;
    assign in_accept  = i_in.valid && in_ready;

    // frame position, pending bits and the packing of one led into a job
    lcfs_packer #(
        .MAX_LEDS    (MAX_LEDS)
    ) u_packer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_count (i_cfg.led_count),
        .i_accept    (in_accept),
        .i_color     (i_in.color),
        .o_job       (job)
    );

    // header zero bytes first, then the completed data bytes, msb first
    lcfs_emitter u_emitter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (in_accept),
        .i_job       (job),
        .o_in_ready  (in_ready),
        .o_status    (emit_status),
        .o_out       (o_out)
    );

    // the frame end byte always closes its color
    a_frame_end_closes_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.last_of_frame) |-> o_out.last_in_item)
        else $error("frame end byte without item end");

    // a taken color occupies the job register next cycle
    a_accept_loads_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> emit_status.busy)
        else $error("accepted color did not load a job");

    // a stalled output keeps the job in progress
    a_stall_holds_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit_status.busy && o_out.valid && !o_out.ready) |=> emit_status.busy)
        else $error("job dropped under output stall");

    // header zero bytes only come from a live job, which holds off new colors
    a_zero_phase_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_status.zero_phase |-> (emit_status.busy && !i_in.ready))
        else $error("header phase outside a job");

endmodule
